### rtl/mst_pkg.sv
// shared types and constants for the maximum spanning tree block
`timescale 1ns / 1ps
package mst_pkg;

  localparam int MAX_NODES = 32;
  localparam int MAX_PAIRS = MAX_NODES * (MAX_NODES - 1) / 2;
  localparam int NODE_W    = 5;
  localparam int CNT_W     = $clog2(MAX_PAIRS + 1);
  localparam int ADDR_W    = $clog2(MAX_PAIRS);
  localparam int NC_W      = 6;
  localparam int W_W       = 32;
  localparam int SUM_W     = 48;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  typedef struct packed {
    logic [NODE_W-1:0]     row_node;
    logic [NODE_W-1:0]     col_node;
    logic signed [W_W-1:0] pair_weight;
    logic                  last_pair;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0]       edge_from;
    logic [NODE_W-1:0]       edge_to;
    logic signed [W_W-1:0]   edge_weight;
    logic signed [SUM_W-1:0] weight_total;
    logic                    last_edge;
  } out_item_t;

  typedef struct packed {
    logic     vld;
    in_item_t item;
  } q_beat_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_TAIL,
    ST_DECIDE,
    ST_FLUSH,
    ST_DONE
  } back_state_t;

endpackage

### rtl/mst_front.sv
// input side: takes beats and buffers them in a short queue
`timescale 1ns / 1ps
module mst_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mst_pkg::in_item_t in_data,
  output mst_pkg::q_beat_t  q_head,
  input  logic              q_pop
);
  import mst_pkg::*;

  in_item_t            qmem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                push;
  logic                pop;

  assign in_stall = (count == (QPTR_W+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && (count != '0);

  assign q_head.vld  = (count != '0);
  assign q_head.item = qmem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

### rtl/mst_back.sv
// build engine: pair store, selection scans, component merge, edge output
`timescale 1ns / 1ps
module mst_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [mst_pkg::NC_W-1:0] node_count,
  input  mst_pkg::q_beat_t   q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output mst_pkg::out_item_t out_data
);
  import mst_pkg::*;

  localparam int ENT_W = 2 * NODE_W + W_W;

  logic [ENT_W-1:0]        mem [MAX_PAIRS];
  back_state_t             state, state_next;
  logic [CNT_W-1:0]        pairs_loaded;
  logic [ADDR_W-1:0]       scan_i;
  logic [ENT_W-1:0]        rd_q;
  logic [ADDR_W-1:0]       rd_idx;
  logic                    rd_vld;
  logic                    found;
  logic [ENT_W-1:0]        best;
  logic [ADDR_W-1:0]       best_idx;
  logic                    have_last;
  logic signed [W_W-1:0]   last_w;
  logic [ADDR_W-1:0]       last_idx;
  logic [NODE_W-1:0]       label [MAX_NODES];
  logic [NODE_W-1:0]       joins_done;
  logic signed [SUM_W-1:0] running_sum;
  logic                    pend_v;
  out_item_t               pend;

  logic signed [W_W-1:0]   rd_w, best_w;
  logic [NODE_W-1:0]       best_a, best_b, la, lb;
  logic                    below_last, above_best, take;
  logic [NC_W-1:0]         nodes;
  logic [NODE_W-1:0]       need;
  logic                    joinable, slot_free, load_ok;
  logic signed [SUM_W-1:0] sum_new;
  logic                    advance, emit;
  out_item_t               flush_item;

  assign rd_w   = rd_q[W_W-1:0];
  assign best_w = best[W_W-1:0];
  assign best_a = best[ENT_W-1 -: NODE_W];
  assign best_b = best[ENT_W-NODE_W-1 -: NODE_W];

  // order is weight descending, later index first on ties
  assign below_last = !have_last || (rd_w < last_w) ||
                      (rd_w == last_w && rd_idx < last_idx);
  assign above_best = !found || (rd_w > best_w) ||
                      (rd_w == best_w && rd_idx > best_idx);
  assign take = rd_vld && below_last && above_best;

  always_comb begin
    if (node_count < NC_W'(2))              nodes = NC_W'(2);
    else if (node_count > NC_W'(MAX_NODES)) nodes = NC_W'(MAX_NODES);
    else                                    nodes = node_count;
  end
  assign need = NODE_W'(nodes - 1'b1);

  assign la       = label[best_a];
  assign lb       = label[best_b];
  assign joinable = ({1'b0, best_a} < nodes) && ({1'b0, best_b} < nodes) && (la != lb);
  assign sum_new  = running_sum + SUM_W'(best_w);
  assign slot_free = !out_valid || !out_stall;
  assign load_ok  = pairs_loaded < CNT_W'(MAX_PAIRS);

  // decide step moves on once a pair was found, unless a join must wait for the edge register
  assign advance = (state == ST_DECIDE) && found && !(joinable && pend_v && !slot_free);
  assign emit    = (advance && joinable && pend_v) ||
                   (state == ST_FLUSH && pend_v && slot_free);

  always_comb begin
    flush_item           = pend;
    flush_item.last_edge = 1'b1;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      ST_LOAD: begin
        q_pop = q_head.vld;
        if (q_head.vld && q_head.item.last_pair) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_i == ADDR_W'(pairs_loaded - 1'b1)) state_next = ST_TAIL;
      end
      ST_TAIL: state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (!found) state_next = ST_FLUSH;
        else if (joinable && pend_v && !slot_free) state_next = ST_DECIDE;
        else if (joinable && joins_done + 1'b1 == need) state_next = ST_FLUSH;
        else state_next = ST_SCAN;
      end
      ST_FLUSH: begin
        if (!pend_v || slot_free) state_next = ST_DONE;
      end
      ST_DONE: state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD && q_head.vld && load_ok) begin
      mem[pairs_loaded[ADDR_W-1:0]] <= {q_head.item.row_node, q_head.item.col_node,
                                        q_head.item.pair_weight};
    end
    rd_q   <= mem[scan_i];
    rd_idx <= scan_i;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      pairs_loaded <= '0;
      scan_i       <= '0;
      rd_vld       <= 1'b0;
      found        <= 1'b0;
      have_last    <= 1'b0;
      joins_done   <= '0;
      running_sum  <= '0;
      pend_v       <= 1'b0;
      out_valid    <= 1'b0;
      for (int k = 0; k < MAX_NODES; k++) label[k] <= NODE_W'(k);
    end else begin
      state  <= state_next;
      rd_vld <= (state == ST_SCAN);
      if (emit) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      if (state == ST_LOAD && q_head.vld && load_ok) pairs_loaded <= pairs_loaded + 1'b1;

      if (state == ST_SCAN) scan_i <= scan_i + 1'b1;

      if ((state == ST_SCAN || state == ST_TAIL) && take) begin
        found    <= 1'b1;
        best     <= rd_q;
        best_idx <= rd_idx;
      end

      if (advance) begin
        have_last <= 1'b1;
        last_w    <= best_w;
        last_idx  <= best_idx;
        found     <= 1'b0;
        scan_i    <= '0;
        if (joinable) begin
          for (int k = 0; k < MAX_NODES; k++) begin
            if (label[k] == lb) label[k] <= la;
          end
          joins_done  <= joins_done + 1'b1;
          running_sum <= sum_new;
          if (pend_v) begin
            out_data <= pend;
          end
          pend_v            <= 1'b1;
          pend.edge_from    <= best_a;
          pend.edge_to      <= best_b;
          pend.edge_weight  <= best_w;
          pend.weight_total <= sum_new;
          pend.last_edge    <= 1'b0;
        end
      end

      // held edge goes out marked last
      if (state == ST_FLUSH && pend_v && slot_free) begin
        out_data <= flush_item;
        pend_v   <= 1'b0;
      end

      if (state == ST_DONE) begin
        pairs_loaded <= '0;
        scan_i       <= '0;
        found        <= 1'b0;
        have_last    <= 1'b0;
        joins_done   <= '0;
        running_sum  <= '0;
        for (int k = 0; k < MAX_NODES; k++) label[k] <= NODE_W'(k);
      end
    end
  end

endmodule

### rtl/max_spanning_tree_kruskal.sv
// top level of the maximum spanning tree block
//
//   channel   direction  handshake               payload
//   in        input      in_valid / in_stall      in_data (pair beat)
//   out       output     out_valid / out_stall    out_data (edge beat)
//   config    input      node_count_we            node_count
//
// loading takes one cycle per pair beat through a four-deep queue
// a build scans the pair store through its registered read port once per selected pair,
//   plus a last scan that finds no pair unless the tree completes first
// reset is synchronous and active high; node_count resets to 32
// in_stall rises only while the queue is full, which happens during a build
// out_stall holds the edge register; the engine waits until it frees
`timescale 1ns / 1ps
module max_spanning_tree_kruskal (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  mst_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output mst_pkg::out_item_t         out_data,
  input  logic                       node_count_we,
  input  logic [mst_pkg::NC_W-1:0]   node_count
);
  import mst_pkg::*;

  logic [NC_W-1:0] node_count_q;   // configured node count
  q_beat_t         q_head;         // head of the pair queue
  logic            q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count_q <= NC_W'(MAX_NODES);
    end else if (node_count_we) begin
      node_count_q <= node_count;
    end
  end

  // front: accept pair beats into the queue
  mst_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  // back: store pairs, pick them by descending weight, merge components
  mst_back u_back (
    .clk        (clk),
    .rst        (rst),
    .node_count (node_count_q),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
